// ===== rtl/core/oaht_pkg.sv =====
`default_nettype none
package oaht_pkg;
	typedef enum logic [2:0] {
		OP_WRITE       = 3'd0,
		OP_READ        = 3'd1,
		OP_POP         = 3'd2,
		OP_GET_DEFAULT = 3'd3,
		OP_SET_DEFAULT = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_FOUND    = 2'd0,
		ST_INSERTED = 2'd1,
		ST_MISSING  = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_READ,
		S_CHECK,
		S_DONE
	} state_t;

	localparam int TAG_BITS = 32;
	localparam logic [TAG_BITS-1:0] TAG_EMPTY = 32'd0;
	localparam logic [TAG_BITS-1:0] TAG_DELETED = 32'd1;
	localparam int FILL_BITS = 11;
	localparam int SLOT_BITS = 10;
endpackage
`default_nettype wire

// ===== rtl/core/open_addressing_hash_table.sv =====
// An accepted request passes through S_READ and S_CHECK once per probe, then S_DONE raises the
// result strobe; an unknown operation takes no probe and goes straight to S_DONE.
// One request at a time: each probe is a memory read state followed by a check state, and
// busy stays high through the result strobe.
// Reset: clears live count and loads fill limit with TABLE_DEPTH*7/10, then a clearing pass
// writes every tag entry empty, one per cycle, with busy high.
`default_nettype none
module open_addressing_hash_table
	import oaht_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_BITS = 32,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [2:0]            operation,
	input  wire logic [KEY_BITS-1:0]   key,
	input  wire logic [31:0]           key_hash,
	input  wire logic [VALUE_BITS-1:0] data_in,
	input  wire logic                  fill_limit_we,
	input  wire logic [FILL_BITS-1:0]  fill_limit,
	output logic                       strobe,
	output logic [1:0]                 status,
	output logic [VALUE_BITS-1:0]      data_out,
	output logic [SLOT_BITS-1:0]       slot
);
	localparam int IW = $clog2(TABLE_DEPTH);

	logic [TAG_BITS-1:0]   tag_mem [TABLE_DEPTH];
	logic [KEY_BITS-1:0]   key_mem [TABLE_DEPTH];
	logic [VALUE_BITS-1:0] val_mem [TABLE_DEPTH];

	state_t state_q, state_d;
	logic [FILL_BITS-1:0]  fill_q, live_q;
	logic [2:0]            op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [TAG_BITS-1:0]   tag_q;
	logic [VALUE_BITS-1:0] din_q;
	logic [IW-1:0]         idx_q;
	logic [IW:0]           n_q;
	logic [TAG_BITS-1:0]   rtag_q;
	logic [KEY_BITS-1:0]   rkey_q;
	logic [VALUE_BITS-1:0] rval_q;
	logic [1:0]            st_q;
	logic [VALUE_BITS-1:0] dout_q;
	logic [IW-1:0]         slot_q;
	logic                  clr_done;
	logic [TAG_BITS-1:0]   tag_in;
	logic                  hit, empty, last, is_ins, fits;

	assign clr_done = (idx_q == IW'(TABLE_DEPTH - 1));
	assign tag_in = (key_hash == TAG_EMPTY || key_hash == TAG_DELETED) ? key_hash + 32'd2
		: key_hash;
	assign empty = (rtag_q == TAG_EMPTY);
	assign hit = (rtag_q == tag_q) && (rkey_q == key_q);
	assign last = (n_q == (IW+1)'(TABLE_DEPTH - 1));
	assign is_ins = (op_q == OP_WRITE) || (op_q == OP_SET_DEFAULT);
	assign fits = ({1'b0, live_q} + 12'd1) <= {1'b0, fill_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_done) state_d = S_IDLE;
			S_IDLE: if (start) state_d = (operation <= OP_SET_DEFAULT) ? S_READ : S_DONE;
			S_READ: state_d = S_CHECK;
			S_CHECK: if (empty || hit || last) state_d = S_DONE; else state_d = S_READ;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != S_IDLE);
		strobe = (state_q == S_DONE);
		status = st_q;
		data_out = dout_q;
		slot = SLOT_BITS'(slot_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			fill_q <= FILL_BITS'(TABLE_DEPTH * 7 / 10);
			live_q <= '0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (fill_limit_we) fill_q <= fill_limit;
			case (state_q)
				S_CLEAR: idx_q <= idx_q + 1'b1;
				S_IDLE: if (start) idx_q <= tag_in[IW-1:0];
				S_CHECK: if (!(empty || hit)) idx_q <= idx_q + IW'(n_q) + IW'(2);
				default: ;
			endcase
			if (state_q == S_CHECK) begin
				if (hit && op_q == OP_POP && live_q != '0) live_q <= live_q - 1'b1;
				else if (!hit && empty && is_ins && fits) live_q <= live_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) tag_mem[idx_q] <= TAG_EMPTY;
		if (state_q == S_IDLE && start) begin
			op_q <= operation;
			key_q <= key;
			tag_q <= tag_in;
			din_q <= data_in;
			n_q <= '0;
			st_q <= ST_MISSING;
			dout_q <= '0;
			slot_q <= '0;
		end
		if (state_q == S_READ) begin
			rtag_q <= tag_mem[idx_q];
			rkey_q <= key_mem[idx_q];
			rval_q <= val_mem[idx_q];
		end
		if (state_q == S_CHECK) begin
			n_q <= n_q + 1'b1;
			if (hit) begin
				st_q <= ST_FOUND;
				slot_q <= idx_q;
				dout_q <= (op_q == OP_WRITE) ? din_q : rval_q;
				if (op_q == OP_WRITE) val_mem[idx_q] <= din_q;
				if (op_q == OP_POP) tag_mem[idx_q] <= TAG_DELETED;
			end else if (empty) begin
				if (is_ins) begin
					if (fits) begin
						tag_mem[idx_q] <= tag_q;
						key_mem[idx_q] <= key_q;
						val_mem[idx_q] <= din_q;
						st_q <= ST_INSERTED;
						dout_q <= din_q;
						slot_q <= idx_q;
					end else begin
						st_q <= ST_FULL;
					end
				end else begin
					st_q <= ST_MISSING;
					slot_q <= idx_q;
					dout_q <= (op_q == OP_READ) ? '0 : din_q;
				end
			end else if (last) begin
				st_q <= is_ins ? ST_FULL : ST_MISSING;
				dout_q <= (is_ins || op_q == OP_READ) ? '0 : din_q;
			end
		end
	end
endmodule
`default_nettype wire

// ===== test/tb_open_addressing_hash_table.sv =====
`default_nettype none
module tb_open_addressing_hash_table;
	timeunit 1ns;
	timeprecision 1ps;
	import oaht_pkg::*;

	localparam int DEPTH = 1024;
	localparam int POOL = 48;
	localparam int RANDOM_WORDS = 930;
	localparam longint CYCLE_LIMIT = 64'd20000000;
	localparam logic [2:0] OP_UNUSED = 3'd7;

	typedef struct {
		status_t     st;
		logic [31:0] dout;
		logic [9:0]  slot;
	} reply_t;

	typedef struct {
		bit          is_cfg;
		logic [2:0]  op;
		logic [31:0] k;
		logic [31:0] h;
		logic [31:0] d;
		bit          typed;
		reply_t      exp;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  operation;
	logic [31:0] key;
	logic [31:0] key_hash;
	logic [31:0] data_in;
	logic        fill_limit_we;
	logic [10:0] fill_limit;
	logic        strobe;
	logic [1:0]  status;
	logic [31:0] data_out;
	logic [9:0]  slot;

	logic [31:0] tags [DEPTH];
	logic [31:0] keys [DEPTH];
	logic [31:0] vals [DEPTH];
	int unsigned entries;
	int unsigned limit_now;

	reply_t      pending_replies [$];
	row_t        directed [$];
	int          mismatches;
	int          idle_pct;
	longint      cycles;
	logic [31:0] pool_key [POOL];
	logic [31:0] pool_hash [POOL];

	open_addressing_hash_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.key(key),
		.key_hash(key_hash),
		.data_in(data_in),
		.fill_limit_we(fill_limit_we),
		.fill_limit(fill_limit),
		.strobe(strobe),
		.status(status),
		.data_out(data_out),
		.slot(slot)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	task automatic table_access(input logic [2:0] op, input logic [31:0] k,
			input logic [31:0] h, input logic [31:0] d, output reply_t r);
		logic [31:0] tag;
		logic [9:0]  idx;
		logic [9:0]  where;
		bit          found;
		bit          has_empty;
		begin
			tag = h;
			if (tag == TAG_EMPTY || tag == TAG_DELETED)
				tag = tag + 32'd2;
			r.st = ST_MISSING;
			r.dout = '0;
			r.slot = '0;
			if (op > OP_SET_DEFAULT)
				return;
			found = 0;
			has_empty = 0;
			where = '0;
			idx = tag[9:0];
			for (int n = 0; n < DEPTH; n++) begin
				if (tags[idx] == TAG_EMPTY) begin
					where = idx;
					has_empty = 1;
					break;
				end
				if (tags[idx] == tag && keys[idx] == k) begin
					where = idx;
					found = 1;
					break;
				end
				idx = idx + 10'(n + 2);
			end
			if (found) begin
				r.st = ST_FOUND;
				r.slot = where;
				if (op == OP_WRITE)
					vals[where] = d;
				r.dout = vals[where];
				if (op == OP_POP) begin
					tags[where] = TAG_DELETED;
					if (entries > 0)
						entries--;
				end
			end else if (op == OP_WRITE || op == OP_SET_DEFAULT) begin
				if (!has_empty || entries + 1 > limit_now) begin
					r.st = ST_FULL;
				end else begin
					tags[where] = tag;
					keys[where] = k;
					vals[where] = d;
					entries++;
					r.st = ST_INSERTED;
					r.dout = d;
					r.slot = where;
				end
			end else begin
				r.slot = where;
				r.dout = (op == OP_READ) ? 32'd0 : d;
			end
		end
	endtask

	task automatic send_word(input logic [2:0] op, input logic [31:0] k,
			input logic [31:0] h, input logic [31:0] d, input bit typed,
			input reply_t exp);
		reply_t r;
		begin
			if ($urandom_range(0, 99) < idle_pct) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			start <= 1'b1;
			operation <= op;
			key <= k;
			key_hash <= h;
			data_in <= d;
			do @(posedge clk); while (busy);
			table_access(op, k, h, d, r);
			pending_replies.push_back(typed ? exp : r);
		end
	endtask

	task automatic write_limit(input logic [10:0] v);
		begin
			start <= 1'b0;
			while (pending_replies.size() != 0 || busy)
				@(posedge clk);
			repeat (4) @(posedge clk);
			fill_limit_we <= 1'b1;
			fill_limit <= v;
			limit_now = v;
			@(posedge clk);
			fill_limit_we <= 1'b0;
		end
	endtask

	function automatic void add_row(bit is_cfg, logic [2:0] op, logic [31:0] k,
			logic [31:0] h, logic [31:0] d, bit typed, status_t st,
			logic [31:0] dout, logic [9:0] s);
		row_t w;
		w.is_cfg = is_cfg;
		w.op = op;
		w.k = k;
		w.h = h;
		w.d = d;
		w.typed = typed;
		w.exp.st = st;
		w.exp.dout = dout;
		w.exp.slot = s;
		directed.push_back(w);
	endfunction

	always @(posedge clk) begin
		reply_t e;
		if (arst_n && strobe) begin
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: status %0d data %h slot %0d",
						status, data_out, slot);
			end else begin
				e = pending_replies.pop_front();
				if (status != e.st || data_out != e.dout || slot != e.slot) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d %h %0d, got %0d %h %0d",
							e.st, e.dout, e.slot, status, data_out, slot);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		reply_t      none;
		logic [2:0]  op;
		logic [31:0] k;
		logic [31:0] h;
		int          p;
		mismatches = 0;
		cycles = 0;
		entries = 0;
		limit_now = 716;
		idle_pct = 20;
		none.st = ST_FOUND;
		none.dout = '0;
		none.slot = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tags[i] = TAG_EMPTY;
			keys[i] = '0;
			vals[i] = '0;
		end
		for (int i = 0; i < POOL; i++) begin
			pool_key[i] = $urandom;
			pool_hash[i] = {22'($urandom_range(0, 4194303)),
				10'($urandom_range(0, 15) * 3)};
		end
		pool_hash[0] = 32'd0;
		pool_hash[1] = 32'd1;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_WRITE;
		key = '0;
		key_hash = '0;
		data_in = '0;
		fill_limit_we = 1'b0;
		fill_limit = '0;

		add_row(0, OP_READ, 32'h5, 32'h100, 32'h55, 1, ST_MISSING, 32'h0, 10'h100);
		add_row(0, OP_WRITE, 32'hA, 32'h0, 32'h11, 1, ST_INSERTED, 32'h11, 10'd2);
		add_row(0, OP_WRITE, 32'hA, 32'h0, 32'h22, 1, ST_FOUND, 32'h22, 10'd2);
		add_row(0, OP_WRITE, 32'hB, 32'h2, 32'h33, 0, ST_FOUND, 0, 0);
		add_row(0, OP_READ, 32'hB, 32'h2, 32'h0, 0, ST_FOUND, 0, 0);
		add_row(0, OP_POP, 32'hA, 32'h0, 32'h99, 1, ST_FOUND, 32'h22, 10'd2);
		add_row(0, OP_READ, 32'hA, 32'h0, 32'h0, 0, ST_FOUND, 0, 0);
		add_row(0, OP_GET_DEFAULT, 32'hA, 32'h0, 32'h77, 0, ST_FOUND, 0, 0);
		add_row(0, OP_SET_DEFAULT, 32'hC, 32'h1, 32'h44, 1, ST_INSERTED, 32'h44, 10'd3);
		add_row(0, OP_SET_DEFAULT, 32'hC, 32'h1, 32'h66, 0, ST_FOUND, 0, 0);
		add_row(0, OP_UNUSED, '1, '1, '1, 1, ST_MISSING, 32'h0, 10'd0);
		add_row(0, OP_WRITE, '1, '1, '1, 1, ST_INSERTED, '1, 10'd1023);
		add_row(0, OP_POP, '1, '1, 32'h0, 1, ST_FOUND, '1, 10'd1023);
		add_row(1, OP_WRITE, 0, 0, 32'd1, 0, ST_FOUND, 0, 0);
		add_row(0, OP_WRITE, 32'h1234, 32'h40, 32'h5, 1, ST_FULL, 32'h0, 10'd0);
		add_row(0, OP_SET_DEFAULT, 32'h1234, 32'h40, 32'h5, 1, ST_FULL, 32'h0, 10'd0);
		add_row(0, OP_GET_DEFAULT, 32'h1234, 32'h40, 32'h9, 0, ST_FOUND, 0, 0);
		add_row(1, OP_WRITE, 0, 0, 32'd1024, 0, ST_FOUND, 0, 0);
		add_row(0, OP_WRITE, 32'h0, 32'h40, 32'h0, 0, ST_FOUND, 0, 0);
		add_row(0, OP_READ, 32'h0, 32'h40, 32'h0, 0, ST_FOUND, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_cfg)
				write_limit(directed[i].d[10:0]);
			else
				send_word(directed[i].op, directed[i].k, directed[i].h,
					directed[i].d, directed[i].typed, directed[i].exp);
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					idle_pct = 20;
					write_limit(11'd716);
				end
				1: begin
					idle_pct = 81;
					write_limit(11'($urandom_range(20, 60)));
				end
				default: begin
					idle_pct = 0;
					write_limit(11'd1024);
				end
			endcase
			for (int n = 0; n < RANDOM_WORDS / 3; n++) begin
				if ($urandom_range(0, 99) < 85) begin
					p = $urandom_range(0, POOL - 1);
					op = 3'($urandom_range(0, 4));
					k = pool_key[p];
					h = pool_hash[p];
				end else begin
					op = 3'($urandom_range(0, 7));
					k = $urandom;
					h = $urandom;
				end
				send_word(op, k, h, $urandom, 0, none);
			end
		end

		start <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
